// ----- sv/meter_frame_descramble_decode_defines.svh -----
// assertion macros for the checker file
`ifndef METER_FRAME_DESCRAMBLE_DECODE_DEFINES_SVH
`define METER_FRAME_DESCRAMBLE_DECODE_DEFINES_SVH

// checked only while out of reset
`define MFDD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MFDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/mfdd_pkg.sv -----
// shared types, constants and the keystream step for the frame descrambler
`timescale 1ns / 1ps
package mfdd_pkg;

	localparam logic [31:0] KEY_INIT = 32'hdfd109e8;
	localparam logic [7:0]  MARKER   = 8'h4B;

	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] CNT_MAX        = 9'd511;
	localparam logic [CNT_W-1:0] IDX_KEY_FIRST  = 9'd2;
	localparam logic [CNT_W-1:0] IDX_KEY_LAST   = 9'd13;
	localparam logic [CNT_W-1:0] IDX_ID_FIRST   = 9'd4;
	localparam logic [CNT_W-1:0] IDX_ID_LAST    = 9'd7;
	localparam logic [CNT_W-1:0] IDX_STAT_FIRST = 9'd11;
	localparam logic [CNT_W-1:0] IDX_STAT_LAST  = 9'd13;
	localparam logic [CNT_W-1:0] HDR_LEN        = 9'd15;
	localparam logic [CNT_W-1:0] PAY_LAST       = 9'd10;
	// index of the last byte for the length thresholds
	localparam logic [CNT_W-1:0] IDX_LEN_MIN    = 9'd19;
	localparam logic [CNT_W-1:0] IDX_LEN_MAX    = 9'd254;
	localparam logic [CNT_W-1:0] IDX_LM_MIN     = 9'd23;
	localparam logic [CNT_W-1:0] IDX_DATE_MIN   = 9'd25;

	localparam int PAY_FIELDS = 10;
	localparam int STAT_BYTES = 3;

	localparam logic [6:0]  YEAR_PIVOT = 7'd80;
	localparam logic [11:0] CENTURY_19 = 12'd1900;
	localparam logic [11:0] CENTURY_20 = 12'd2000;

	localparam int REC_W           = 152;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef struct packed {
		logic                          len_ok;
		logic                          marker_ok;
		logic                          lm_ok;
		logic                          date_ok;
		logic [31:0]                   meter_id;
		logic [STAT_BYTES-1:0][7:0]    status;
		logic [PAY_FIELDS-1:0][7:0]    payload;
	} frame_sum_t;

	typedef struct packed {
		logic [11:0] alarm_flags;
		logic [15:0] transmit_period_s;
		logic [4:0]  battery_half_years;
		logic [4:0]  date_day;
		logic [3:0]  date_month;
		logic [11:0] date_year;
		logic        date_present;
		logic        last_month_present;
		logic [31:0] last_month_liters;
		logic [31:0] total_liters;
		logic [31:0] meter_id;
	} record_t;

	function automatic logic [31:0] lfsr8(input logic [31:0] k_in);
		logic [31:0] k;
		k = k_in;
		for (int i = 0; i < 8; i++) begin
			k = {k[30:0], k[1] ^ k[2] ^ k[11] ^ k[31]};
		end
		return k;
	endfunction

endpackage

// ----- sv/mfdd_front.sv -----
// byte intake: key build, descrambling and capture of one frame summary
`timescale 1ns / 1ps
module mfdd_front
	import mfdd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	input  logic       push_ready,
	output frame_sum_t push_data
);

	logic [CNT_W-1:0]             cnt_q;
	logic [31:0]                  key_q;
	logic [31:0]                  id_q;
	logic [STAT_BYTES-1:0][7:0]   stat_q;
	logic                         marker_q;
	logic [PAY_FIELDS-1:0][7:0]   pay_q;

	logic [31:0]                  key_x, key_n, id_n;
	logic [STAT_BYTES-1:0][7:0]   stat_n;
	logic [PAY_FIELDS-1:0][7:0]   pay_n;
	logic                         marker_n;
	logic [CNT_W-1:0]             pidx;
	logic [1:0]                   lane;
	logic [7:0]                   plain;
	logic                         accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_last;

	always_comb begin
		key_x    = key_q;
		id_n     = id_q;
		stat_n   = stat_q;
		pay_n    = pay_q;
		marker_n = marker_q;
		pidx     = cnt_q - HDR_LEN;
		lane     = 2'd3 - 2'(cnt_q - IDX_KEY_FIRST);
		if (cnt_q >= IDX_KEY_FIRST && cnt_q <= IDX_KEY_LAST) begin
			key_x[{lane, 3'b000} +: 8] = key_q[{lane, 3'b000} +: 8] ^ in_byte;
		end
		key_n = (cnt_q >= HDR_LEN) ? lfsr8(key_x) : key_x;
		plain = in_byte ^ key_n[7:0];
		if (cnt_q >= IDX_ID_FIRST && cnt_q <= IDX_ID_LAST) begin
			id_n[{2'(cnt_q - IDX_ID_FIRST), 3'b000} +: 8] = in_byte;
		end
		if (cnt_q >= IDX_STAT_FIRST && cnt_q <= IDX_STAT_LAST) begin
			stat_n[2'(cnt_q - IDX_STAT_FIRST)] = in_byte;
		end
		if (cnt_q >= HDR_LEN) begin
			if (pidx == '0) begin
				marker_n = (plain == MARKER);
			end else if (pidx <= PAY_LAST) begin
				pay_n[4'(pidx - 9'd1)] = plain;
			end
		end
	end

	always_comb begin
		push_data.len_ok    = (cnt_q >= IDX_LEN_MIN) && (cnt_q <= IDX_LEN_MAX);
		push_data.marker_ok = marker_n;
		push_data.lm_ok     = (cnt_q >= IDX_LM_MIN);
		push_data.date_ok   = (cnt_q >= IDX_DATE_MIN);
		push_data.meter_id  = id_n;
		push_data.status    = stat_n;
		push_data.payload   = pay_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			key_q    <= KEY_INIT;
			id_q     <= '0;
			stat_q   <= '0;
			marker_q <= 1'b0;
			pay_q    <= '0;
		end else if (accept) begin
			if (in_last) begin
				cnt_q    <= '0;
				key_q    <= KEY_INIT;
				id_q     <= '0;
				stat_q   <= '0;
				marker_q <= 1'b0;
				pay_q    <= '0;
			end else begin
				if (cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + 9'd1;
				end
				key_q    <= key_n;
				id_q     <= id_n;
				stat_q   <= stat_n;
				marker_q <= marker_n;
				pay_q    <= pay_n;
			end
		end
	end

endmodule

// ----- sv/mfdd_queue.sv -----
// small queue of frame summaries between intake and decode
`timescale 1ns / 1ps
module mfdd_queue
	import mfdd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  frame_sum_t wr_data,
	output logic       rd_valid,
	input  logic       rd_ready,
	output frame_sum_t rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W_Q = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

	frame_sum_t              mem_q [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CNT_W_Q-1:0]      fill_q;
	logic                    do_wr, do_rd;

	assign wr_ready = (fill_q != CNT_FULL);
	assign rd_valid = (fill_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + CNT_W_Q'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - CNT_W_Q'(1);
			end
		end
	end

endmodule

// ----- sv/mfdd_back.sv -----
// record decode from a frame summary into the output register
`timescale 1ns / 1ps
module mfdd_back
	import mfdd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sum_valid,
	output logic       sum_ready,
	input  frame_sum_t sum_data,
	output logic       out_valid,
	input  logic       out_ready,
	output record_t    out_rec,
	output logic       out_ok
);

	record_t     rec;
	logic        ok;
	logic [7:0]  s11, s12, s13, p9, p10;
	logic [6:0]  yy;
	logic [4:0]  sh;
	logic [17:0] period;
	logic        valid_q;
	record_t     rec_q;
	logic        ok_q;

	assign sum_ready = sum_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_rec   = rec_q;
	assign out_ok    = ok_q;

	always_comb begin
		s11    = sum_data.status[0];
		s12    = sum_data.status[1];
		s13    = sum_data.status[2];
		p9     = sum_data.payload[8];
		p10    = sum_data.payload[9];
		yy     = {p10[7:4], p9[7:5]};
		sh     = {1'b0, s11[3:0]} + 5'd2;
		period = 18'd1 << sh;
		ok     = sum_data.len_ok && sum_data.marker_ok;
		rec    = '0;
		if (sum_data.len_ok) begin
			rec.meter_id = sum_data.meter_id;
		end
		if (ok) begin
			rec.total_liters = {sum_data.payload[3], sum_data.payload[2],
				sum_data.payload[1], sum_data.payload[0]};
			if (sum_data.lm_ok) begin
				rec.last_month_liters = {sum_data.payload[7], sum_data.payload[6],
					sum_data.payload[5], sum_data.payload[4]};
				rec.last_month_present = 1'b1;
			end
			if (sum_data.date_ok) begin
				rec.date_present = 1'b1;
				rec.date_year    = (yy > YEAR_PIVOT) ? CENTURY_19 + 12'(yy)
					: CENTURY_20 + 12'(yy);
				rec.date_month   = p10[3:0];
				rec.date_day     = p9[4:0];
			end
			rec.battery_half_years = s12[4:0];
			rec.transmit_period_s  = period[15:0];
			rec.alarm_flags = {s13[0], s13[2], s12[6], s13[1], s13[3], s13[4],
				s13[5], s13[6], s13[7], s12[5], s12[7], s11[7]};
		end
	end

	always_ff @(posedge clk) begin
		if (sum_ready) begin
			rec_q <= rec;
			ok_q  <= ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sum_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ----- sv/meter_frame_descramble_decode.sv -----
// top level of the meter radio frame descrambler and decoder
// Takes one frame byte per cycle with no gaps needed between frames; tready
// drops only while the summary queue is full, that is while QUEUE_DEPTH
// finished frames wait behind a stalled output. Every byte is handled in the
// cycle it is accepted (key build, eight keystream steps and capture); the
// last byte of a frame pushes a summary into the queue, from which the record
// is decoded into the output register before it appears on the output.
// Records leave through the output register at up to one per cycle while m_axis_tready is high.
`timescale 1ns / 1ps
module meter_frame_descramble_decode
	import mfdd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // data_byte
	input  logic             s_axis_tlast,  // end_of_frame
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// meter_id, total_liters, last_month_liters, last_month_present,
	// date_present, date_year, date_month, date_day, battery_half_years,
	// transmit_period_s, alarm_flags
	output logic [REC_W-1:0] m_axis_tdata,
	output logic             m_axis_tuser   // frame_valid
);

	logic       push, push_ready, sum_valid, sum_ready;
	frame_sum_t push_data, sum_data;
	record_t    rec;

	mfdd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.push      (push),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	mfdd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push),
		.wr_ready(push_ready),
		.wr_data (push_data),
		.rd_valid(sum_valid),
		.rd_ready(sum_ready),
		.rd_data (sum_data)
	);

	mfdd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.sum_valid(sum_valid),
		.sum_ready(sum_ready),
		.sum_data (sum_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_rec  (rec),
		.out_ok   (m_axis_tuser)
	);

	assign m_axis_tdata = rec;

endmodule

// ----- sv/mfdd_checker.sv -----
// port-level checks for the frame descrambler, bound to the top level
`timescale 1ns / 1ps
`include "meter_frame_descramble_decode_defines.svh"
module mfdd_checker
	import mfdd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [7:0]       s_axis_tdata,
	input logic             s_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [REC_W-1:0] m_axis_tdata,
	input logic             m_axis_tuser
);

	`MFDD_ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |-> !m_axis_tvalid, "item out during reset")
	`MFDD_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled item changed")
	`MFDD_ASSERT(a_invalid_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[REC_W-1:32] == '0, "invalid record carries fields")
	`MFDD_ASSERT(a_date_needs_lm, clk, arst_n, m_axis_tvalid && m_axis_tdata[97] |-> m_axis_tdata[96] && m_axis_tuser, "date without last month")

endmodule

bind meter_frame_descramble_decode mfdd_checker u_mfdd_checker (.*);

// ----- bench/tb_meter_frame_descramble_decode.sv -----
// self-checking bench for the meter frame descrambler: directed and random frames, checked records
`timescale 1ns / 1ps
module tb_meter_frame_descramble_decode;
	import mfdd_pkg::*;

	localparam int CYCLE_LIMIT  = 500_000;
	localparam int TOTAL_BYTES  = 1950;
	localparam int MAX_REPORTS  = 60;
	localparam logic [31:0] FEEDBACK_TAPS = 32'h8000_0806;

	typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;

	typedef struct packed {
		logic    frame_valid;
		record_t rec;
	} frame_result_t;

	typedef struct packed {
		logic [15:0] len;
		fill_kind_t  fill;
		logic        marker_good;
		logic        typed;
		logic        exp_valid;
		logic [31:0] exp_id;
	} frame_case_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;
	logic             s_axis_tlast;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [REC_W-1:0] m_axis_tdata;
	logic             m_axis_tuser;

	// predictor state for the frame in flight
	logic [8:0]  frame_count;
	logic [31:0] frame_key;
	logic [31:0] frame_id;
	logic [7:0]  frame_status [3];
	logic        frame_marker;
	logic [7:0]  frame_payload [10];

	frame_result_t expected_records [$];
	frame_result_t want;
	record_t       got_rec;

	int  error_count;
	int  cycle_count;
	int  bytes_sent;
	int  frames_sent;
	int  valid_frames;
	bit  sender_steady;
	bit  receiver_steady;

	frame_case_t frame_cases [14] = '{
		'{16'd1,   FILL_ZERO,   1'b1, 1'b1, 1'b0, 32'h0000_0000},
		'{16'd19,  FILL_ONES,   1'b1, 1'b1, 1'b0, 32'h0000_0000},
		'{16'd20,  FILL_ONES,   1'b0, 1'b1, 1'b0, 32'hffff_ffff},
		'{16'd20,  FILL_ZERO,   1'b1, 1'b0, 1'b0, 32'h0000_0000},
		'{16'd23,  FILL_RANDOM, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
		'{16'd24,  FILL_RANDOM, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
		'{16'd25,  FILL_RANDOM, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
		'{16'd26,  FILL_ONES,   1'b1, 1'b0, 1'b0, 32'h0000_0000},
		'{16'd255, FILL_RANDOM, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
		'{16'd256, FILL_ONES,   1'b1, 1'b1, 1'b0, 32'h0000_0000},
		'{16'd600, FILL_RANDOM, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
		'{16'd30,  FILL_ZERO,   1'b1, 1'b0, 1'b0, 32'h0000_0000},
		'{16'd16,  FILL_RANDOM, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
		'{16'd40,  FILL_RANDOM, 1'b0, 1'b0, 1'b0, 32'h0000_0000}
	};

	meter_frame_descramble_decode i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] advance_key(input logic [31:0] k);
		logic [31:0] r;
		r = k;
		repeat (8) r = {r[30:0], ^(r & FEEDBACK_TAPS)};
		return r;
	endfunction

	function automatic logic [7:0] pick_byte(input fill_kind_t fill);
		case (fill)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hff;
			default:   return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic clear_frame_state();
		frame_count  = '0;
		frame_key    = KEY_INIT;
		frame_id     = '0;
		frame_marker = 1'b0;
		foreach (frame_status[i]) frame_status[i] = '0;
		foreach (frame_payload[i]) frame_payload[i] = '0;
	endtask

	task automatic absorb_byte(input logic [7:0] b, input logic last, output bit done,
			output frame_result_t res);
		int idx;
		int len;
		int shift;
		logic [7:0] d;
		logic [6:0] yy;
		logic [7:0] s11;
		logic [7:0] s12;
		logic [7:0] s13;
		logic [31:0] period;
		idx  = int'(frame_count);
		res  = '0;
		done = 1'b0;
		if (idx >= 2 && idx <= 13)
			frame_key = frame_key ^ (32'(b) << (8 * (3 - ((idx - 2) % 4))));
		if (idx >= 4 && idx <= 7)
			frame_id = frame_id | (32'(b) << (8 * (idx - 4)));
		if (idx >= 11 && idx <= 13)
			frame_status[idx - 11] = b;
		if (idx >= 15) begin
			frame_key = advance_key(frame_key);
			d = b ^ frame_key[7:0];
			if (idx == 15)
				frame_marker = (d == MARKER);
			else if (idx <= 25)
				frame_payload[idx - 16] = d;
		end
		if (frame_count != '1)
			frame_count = frame_count + 9'd1;
		if (last) begin
			done = 1'b1;
			len  = idx + 1;
			if (len >= 20 && len <= 255) begin
				res.rec.meter_id = frame_id;
				if (frame_marker) begin
					s11 = frame_status[0];
					s12 = frame_status[1];
					s13 = frame_status[2];
					res.frame_valid      = 1'b1;
					res.rec.total_liters = {frame_payload[3], frame_payload[2],
						frame_payload[1], frame_payload[0]};
					if (len - 15 >= 9) begin
						res.rec.last_month_liters = {frame_payload[7], frame_payload[6],
							frame_payload[5], frame_payload[4]};
						res.rec.last_month_present = 1'b1;
					end
					if (len - 15 >= 11) begin
						yy = {frame_payload[9][7:4], frame_payload[8][7:5]};
						res.rec.date_present = 1'b1;
						res.rec.date_year    = (yy > 7'd80) ? 12'(yy) + 12'd1900 : 12'(yy) + 12'd2000;
						res.rec.date_month   = frame_payload[9][3:0];
						res.rec.date_day     = frame_payload[8][4:0];
					end
					shift  = int'(s11[3:0]) + 2;
					period = 32'd1 << shift;
					res.rec.battery_half_years = s12[4:0];
					res.rec.transmit_period_s  = period[15:0];
					res.rec.alarm_flags = {s13[0], s13[2], s12[6], s13[1], s13[3], s13[4],
						s13[5], s13[6], s13[7], s12[5], s12[7], s11[7]};
				end
			end
			clear_frame_state();
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input frame_result_t typed_res);
		int gap;
		bit done;
		frame_result_t res;
		gap = sender_steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		absorb_byte(b, last, done, res);
		if (done) begin
			if (typed)
				res = typed_res;
			expected_records.push_back(res);
			frames_sent++;
			if (res.frame_valid)
				valid_frames++;
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int len, input fill_kind_t fill, input logic marker_good,
			input bit typed, input logic exp_valid, input logic [31:0] exp_id);
		logic [7:0] hdr [15];
		logic [7:0] plain;
		logic [7:0] raw;
		logic [31:0] ks;
		frame_result_t typed_res;
		typed_res                 = '0;
		typed_res.frame_valid     = exp_valid;
		typed_res.rec.meter_id    = exp_id;
		sender_steady             = ($urandom_range(0, 4) == 0);
		foreach (hdr[i]) hdr[i] = pick_byte(fill);
		ks = KEY_INIT ^ {hdr[2], hdr[3], hdr[4], hdr[5]} ^ {hdr[6], hdr[7], hdr[8], hdr[9]}
			^ {hdr[10], hdr[11], hdr[12], hdr[13]};
		for (int i = 0; i < len; i++) begin
			if (i < 15) begin
				raw = hdr[i];
			end else begin
				ks = advance_key(ks);
				if (i == 15)
					plain = marker_good ? MARKER : MARKER ^ 8'($urandom_range(1, 255));
				else
					plain = pick_byte(fill);
				raw = plain ^ ks[7:0];
			end
			send_byte(raw, i == len - 1, typed, typed_res);
		end
	endtask

	task automatic wait_for_records();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_records.size() != 0) @(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, exp_val);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_meter_frame_descramble_decode: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_rec = m_axis_tdata;
			if (expected_records.size() == 0) begin
				report_mismatch("record with nothing pending, frame_valid", 32'(m_axis_tuser), 0);
			end else begin
				want = expected_records.pop_front();
				if (m_axis_tuser !== want.frame_valid)
					report_mismatch("frame_valid", 32'(m_axis_tuser), 32'(want.frame_valid));
				if (got_rec.meter_id !== want.rec.meter_id)
					report_mismatch("meter_id", got_rec.meter_id, want.rec.meter_id);
				if (got_rec.total_liters !== want.rec.total_liters)
					report_mismatch("total_liters", got_rec.total_liters, want.rec.total_liters);
				if (got_rec.last_month_liters !== want.rec.last_month_liters)
					report_mismatch("last_month_liters", got_rec.last_month_liters,
						want.rec.last_month_liters);
				if (got_rec.last_month_present !== want.rec.last_month_present)
					report_mismatch("last_month_present", 32'(got_rec.last_month_present),
						32'(want.rec.last_month_present));
				if (got_rec.date_present !== want.rec.date_present)
					report_mismatch("date_present", 32'(got_rec.date_present),
						32'(want.rec.date_present));
				if (got_rec.date_year !== want.rec.date_year)
					report_mismatch("date_year", 32'(got_rec.date_year), 32'(want.rec.date_year));
				if (got_rec.date_month !== want.rec.date_month)
					report_mismatch("date_month", 32'(got_rec.date_month), 32'(want.rec.date_month));
				if (got_rec.date_day !== want.rec.date_day)
					report_mismatch("date_day", 32'(got_rec.date_day), 32'(want.rec.date_day));
				if (got_rec.battery_half_years !== want.rec.battery_half_years)
					report_mismatch("battery_half_years", 32'(got_rec.battery_half_years),
						32'(want.rec.battery_half_years));
				if (got_rec.transmit_period_s !== want.rec.transmit_period_s)
					report_mismatch("transmit_period_s", 32'(got_rec.transmit_period_s),
						32'(want.rec.transmit_period_s));
				if (got_rec.alarm_flags !== want.rec.alarm_flags)
					report_mismatch("alarm_flags", 32'(got_rec.alarm_flags),
						32'(want.rec.alarm_flags));
			end
		end
	end

	// output side back-pressure
	initial begin
		int gap;
		m_axis_tready   = 1'b0;
		receiver_steady = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				receiver_steady = ~receiver_steady;
			gap = receiver_steady ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		int r;
		int len;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		error_count   = 0;
		cycle_count   = 0;
		bytes_sent    = 0;
		frames_sent   = 0;
		valid_frames  = 0;
		sender_steady = 1'b0;
		clear_frame_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (frame_cases[i])
			send_frame(int'(frame_cases[i].len), frame_cases[i].fill, frame_cases[i].marker_good,
				frame_cases[i].typed, frame_cases[i].exp_valid, frame_cases[i].exp_id);
		wait_for_records();

		while (bytes_sent < TOTAL_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				len = $urandom_range(1, 19);
			else if (r < 14)
				len = $urandom_range(200, 300);
			else
				len = $urandom_range(20, 40);
			send_frame(len, FILL_RANDOM, $urandom_range(0, 9) != 0, 1'b0, 1'b0, 32'h0);
			if ($urandom_range(0, 15) == 0)
				wait_for_records();
		end

		s_axis_tvalid <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d bytes in %0d frames, %0d decoded as valid records", bytes_sent,
			frames_sent, valid_frames);
		$display("lengths 1 to 600, marker hits and misses, random stalls on both sides");
		if (error_count == 0)
			$display("tb_meter_frame_descramble_decode: clean");
		else
			$display("tb_meter_frame_descramble_decode: errors");
		$finish;
	end

endmodule
